[hw/rtl/ubrf_pkg.sv]
// package for the uart byte ring fifo: payload types, codes and constants
`timescale 1ns / 1ps
`default_nettype none

package ubrf_pkg;

    localparam int DEPTH = 256;
    localparam int IDX_W = $clog2(DEPTH);

    localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;
    localparam logic [7:0] SIZE_RESET      = 8'd255;
    localparam logic [7:0] SIZE_MIN        = 8'd2;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_DROP    = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_in;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_out;
        logic [7:0] fill_count;
        logic       not_empty;
    } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/uart_byte_ring_fifo.sv]
// top level of the uart byte ring fifo: sequencer, ring pointers and byte store
`timescale 1ns / 1ps
`default_nettype none

// Byte ring FIFO for a UART receive path.
// Command channel: cmd is taken at a rising edge with start high and busy low.
// Every command returns one beat on result, marked by result_valid for one
// cycle; the receiver cannot stall it.
// Enqueue, dequeue and clear pass through S_EXEC: the store is read at the head
// into a register while idle, the command executes in the next cycle and the
// result beat shows in the cycle after that, with busy low again.
// Drop walks the store one byte a cycle through the single head advance and
// compare unit, discarding each byte, and stops after it discards a carriage
// return or when it runs the queue empty.
// Configuration: cfg_data sets the ring size on a cfg_valid / cfg_ready beat;
// cfg_ready is high only while idle and no command is starting. A write
// empties the queue. Size values 0 and 1 act as 2; capacity is size - 1.
// Reset empties the queue and sets the size to 255; store contents stay
// undefined and are never read before being written.
// fill_count and not_empty report the occupancy after each command.
module uart_byte_ring_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ubrf_pkg::cmd_t cmd,
    output logic               result_valid,
    output ubrf_pkg::rsp_t     result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_data
);
    import ubrf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DROP
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [7:0]       count_reg, count_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic             result_valid_reg, result_valid_next;
    rsp_t             result_reg, result_next;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;
    logic             wr_en;

    logic             accept;
    logic             cfg_write;
    logic             empty;
    logic             full;
    logic [IDX_W-1:0] head_adv;
    logic [IDX_W-1:0] tail_adv;
    logic [7:0]       size_clamped;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    assign empty    = (head_reg == tail_reg);
    assign full     = (count_reg == 8'(last_reg));
    assign head_adv = (head_reg == last_reg) ? '0 : head_reg + 1'b1;
    assign tail_adv = (tail_reg == last_reg) ? '0 : tail_reg + 1'b1;

    assign size_clamped = (cfg_data < SIZE_MIN) ? SIZE_MIN : cfg_data;

    assign wr_en = (state_reg == S_EXEC) && (cmd_reg.operation == OP_ENQUEUE) && !full;

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        last_next         = last_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_write)
                begin
                    last_next  = IDX_W'(size_clamped - 8'd1);
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                else if (accept)
                begin
                    cmd_next   = cmd;
                    state_next = (cmd.operation == OP_DROP) ? S_DROP : S_EXEC;
                end
            end

            S_EXEC:
            begin
                result_next.status   = ST_OK;
                result_next.data_out = '0;
                case (cmd_reg.operation)
                    OP_ENQUEUE:
                    begin
                        if (full)
                        begin
                            result_next.status = ST_FULL;
                        end
                        else
                        begin
                            tail_next  = tail_adv;
                            count_next = count_reg + 8'd1;
                        end
                    end
                    OP_DEQUEUE:
                    begin
                        if (empty)
                        begin
                            result_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            result_next.data_out = rd_data_reg;
                            head_next            = head_adv;
                            count_next           = count_reg - 8'd1;
                        end
                    end
                    default:
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end
                endcase
                result_next.fill_count = count_next;
                result_next.not_empty  = (count_next != 8'd0);
                result_valid_next      = 1'b1;
                state_next             = S_IDLE;
            end

            S_DROP:
            begin
                // rd_data_reg always holds the byte at the current head
                if (!empty)
                begin
                    head_next  = head_adv;
                    count_next = count_reg - 8'd1;
                end
                if (empty || (rd_data_reg == CARRIAGE_RETURN))
                begin
                    result_next.status     = ST_OK;
                    result_next.data_out   = '0;
                    result_next.fill_count = count_next;
                    result_next.not_empty  = (count_next != 8'd0);
                    result_valid_next      = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cmd_reg          <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            last_reg         <= IDX_W'(SIZE_RESET - 8'd1);
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cmd_reg          <= cmd_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            last_reg         <= last_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    // byte store, read at the next head so the walk sees one byte a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= cmd_reg.data_in;
        end
        rd_data_reg <= mem[head_next];
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 8'(last_reg))
        else $error("fill count above capacity");

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 8'd0) == (head_reg == tail_reg))
        else $error("fill count disagrees with ring pointers");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> ($past(state_reg) != S_IDLE) && (state_reg == S_IDLE))
        else $error("result beat without a finished command");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");
`endif

endmodule

`default_nettype wire
